// ===== rtl/particle_pool_simulator_macros.svh =====
// Assertion macros shared by the particle pool RTL.
// Expects a clock aclk and an active-low reset aresetn in the calling module.
`ifndef PARTICLE_POOL_SIMULATOR_MACROS_SVH
`define PARTICLE_POOL_SIMULATOR_MACROS_SVH

// cond must never hold outside reset
`define PPSIM_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define PPSIM_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define PPSIM_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ppsim_pkg.sv =====
// Types, constants and helpers for the particle pool simulator.
// No dependencies; used by every module of the block.
package ppsim_pkg;

    // one result word before packing
    typedef struct packed {
        logic        last;
        logic        empty;
        logic [62:0] dsq;
        logic [7:0]  alpha;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] size;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
        logic [5:0]  slot;
    } res_t;

    // one particle memory entry
    typedef struct packed {
        logic [7:0]  alpha;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] size;
        logic [31:0] spd_z;
        logic [31:0] spd_y;
        logic [31:0] spd_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } part_t;

    localparam logic [31:0] LIFE_INIT  = 32'h0005_0000;
    localparam logic [31:0] POS_Z_INIT = 32'hFFEC_0000;
    localparam logic [31:0] SPD_Y_BASE = 32'h000A_0000;
    localparam logic [19:0] GRAV_K     = 20'd642908;
    localparam logic [24:0] RECIP_K    = 25'd17179870;  // ceil(2^31 / 125)
    localparam logic [23:0] DIV_BIAS   = 24'd62;
    localparam logic [62:0] DIST_MAX   = {63{1'b1}};

    function automatic logic [31:0] sat32(input logic [34:0] v);
        logic [31:0] r;
        if (!v[34] && (v[33:31] != 3'b000)) begin
            r = 32'h7FFF_FFFF;
        end else if (v[34] && (v[33:31] != 3'b111)) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ppsim_spawn_calc.sv =====
// Spawn arithmetic: direction speeds and size through one shared
// reciprocal multiplier for division by 125. Uses ppsim_pkg.
module ppsim_spawn_calc (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [10:0] dir_x,
    input  logic signed [10:0] dir_y,
    input  logic signed [10:0] dir_z,
    input  logic [9:0]         size_code,
    output logic               done,
    output logic [31:0]        spd_x,
    output logic [31:0]        spd_y,
    output logic [31:0]        spd_z,
    output logic [15:0]        size
);
    import ppsim_pkg::*;

    logic [2:0]  k_reg;
    logic        run_reg;
    logic        pv_reg;
    logic [1:0]  pk_reg;
    logic [48:0] prod_reg;
    logic [17:0] quot_reg [4];
    logic        done_reg;
    logic [10:0] mag;
    logic [23:0] num;

    always_comb begin
        case (k_reg)
            3'd0:    mag = dir_x[10] ? 11'(-dir_x) : dir_x[10:0];
            3'd1:    mag = dir_y[10] ? 11'(-dir_y) : dir_y[10:0];
            3'd2:    mag = dir_z[10] ? 11'(-dir_z) : dir_z[10:0];
            default: mag = 11'd0;
        endcase
        // (x * 12288 + 62) for speeds, ((code + 200) * 4096 + 62) for size
        if (k_reg == 3'd3) begin
            num = {12'({2'b00, size_code} + 12'd200), 12'd0} + DIV_BIAS;
        end else begin
            num = {12'({1'b0, mag} * 12'd3), 12'd0} + DIV_BIAS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            k_reg    <= 3'd0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                run_reg <= 1'b1;
                k_reg   <= 3'd0;
            end else if (run_reg) begin
                k_reg <= k_reg + 3'd1;
                if (k_reg == 3'd3) begin
                    run_reg <= 1'b0;
                end
            end
            pv_reg   <= run_reg && !start;
            done_reg <= pv_reg && (pk_reg == 2'd3);
        end
    end

    always_ff @(posedge aclk) begin
        if (run_reg) begin
            prod_reg <= 49'(num) * 49'(RECIP_K);
            pk_reg   <= k_reg[1:0];
        end
        if (pv_reg) begin
            quot_reg[pk_reg] <= prod_reg[48:31];
        end
    end

    assign done  = done_reg;
    assign spd_x = dir_x[10] ? -32'(quot_reg[0]) : 32'(quot_reg[0]);
    assign spd_y = SPD_Y_BASE + (dir_y[10] ? -32'(quot_reg[1]) : 32'(quot_reg[1]));
    assign spd_z = dir_z[10] ? -32'(quot_reg[2]) : 32'(quot_reg[2]);
    assign size  = quot_reg[3][15:0];

endmodule

// ===== rtl/ppsim_dist_sq.sv =====
// Squared camera distance: per-axis squares, then saturating sum.
// Two enabled stages; uses ppsim_pkg for the result type.
module ppsim_dist_sq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  ppsim_pkg::res_t   in_res,
    input  logic [31:0]       in_mag [3],
    output logic              out_vld,
    output ppsim_pkg::res_t   out_res,
    output logic              busy
);
    import ppsim_pkg::*;

    logic        s1_vld_reg;
    res_t        s1_res_reg;
    logic [63:0] sq_reg [3];
    logic        s2_vld_reg;
    res_t        s2_res_reg;
    logic [65:0] sum;
    res_t        s2_in;

    assign sum = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);

    always_comb begin
        s2_in     = s1_res_reg;
        s2_in.dsq = (sum > 66'(DIST_MAX)) ? DIST_MAX : sum[62:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_res_reg <= in_res;
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= 64'(in_mag[k]) * 64'(in_mag[k]);
            end
            s2_res_reg <= s2_in;
        end
    end

    assign out_vld = s2_vld_reg;
    assign out_res = s2_res_reg;
    assign busy    = s1_vld_reg || s2_vld_reg;

endmodule

// ===== rtl/particle_pool_simulator.sv =====
// Top level of the particle pool: life and particle memories, spawn search,
// tick pipeline and output buffering. Uses ppsim_pkg, ppsim_spawn_calc,
// ppsim_dist_sq and the assertion macros.
//
//  channel | ports          | words
//  --------+----------------+--------------------------------------------
//  input   | s_tvalid/ready | one spawn or tick command, kind on s_tuser
//  result  | m_tvalid/ready | one particle report, empty flag, tlast
//
// A tick does one memory read per slot, then the motion and distance pipeline
// drains. A spawn searches slots until the first free one, or every slot
// when the pool is full.
// Reset makes every slot free at once through per-slot valid bits.
// A stalled result side holds the tick pipeline; input waits until done.
`include "particle_pool_simulator_macros.svh"

module particle_pool_simulator #(
    parameter int POOL_SIZE = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dir_x, dir_y, dir_z, red, green, blue, alpha, size_code, delta_time,
    // camera_x, camera_yz, 6 zero bits
    input  logic [191:0] s_tdata,
    // operation
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot, pos_x, pos_y, pos_z, size_out, red_out, green_out, blue_out,
    // alpha_out, distance_sq, 3 zero bits
    output logic [215:0] m_tdata,
    // empty_res
    output logic         m_tuser,
    output logic         m_tlast
);
    import ppsim_pkg::*;

    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_CALC = 6'b000100,
        ST_SPWR = 6'b001000,
        ST_TICK = 6'b010000,
        ST_TEND = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [10:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic [9:0]  size_code_reg;
    logic [15:0] delta_reg;
    logic [31:0] cam_reg [3];
    logic [18:0] gstep_reg;

    logic [IW-1:0]      lu_reg, scan_addr_reg, slot_reg;
    logic [CW-1:0]      cnt_reg;
    logic               found_reg;
    logic [POOL_SIZE-1:0] valid_reg;

    logic [31:0] life_mem [POOL_SIZE];
    part_t       part_mem [POOL_SIZE];
    logic [31:0] life_q;
    part_t       part_q;
    logic        lv_q;

    logic          a_vld_reg, a_last_reg;
    logic [IW-1:0] a_slot_reg;
    logic          b_vld_reg;
    logic [IW-1:0] b_slot_reg;
    part_t         b_part_reg;
    logic          c_vld_reg;
    logic [IW-1:0] c_slot_reg;
    part_t         c_part_reg;
    logic [49:0]   c_prod_reg [3];
    logic          d_vld_reg;
    res_t          d_res_reg;
    logic [31:0]   d_mag_reg [3];

    logic pend_vld_reg, out_vld_reg;
    res_t pend_reg, out_reg;

    logic          accept, adv, stall, out_free, issue_v;
    logic [IW-1:0] rd_addr;
    logic          scan_hit, scan_miss, alive0, surv, tick_a;
    logic [31:0]   life_new, spdy_new;
    logic          life_we, part_we;
    logic [IW-1:0] life_wa, part_wa;
    logic [31:0]   life_wd;
    part_t         part_wd, spawn_part, c_part_new, b_part_in;
    res_t          spawn_res, empty_res_w, o_res, pend_last;
    logic          o_vld, dist_busy, calc_done, calc_start;
    logic [31:0]   calc_spd_x, calc_spd_y, calc_spd_z;
    logic [15:0]   calc_size;
    logic [31:0]   b_spd [3];
    logic [31:0]   c_pos [3];
    logic [31:0]   pos_new [3];
    logic [32:0]   diff [3];
    logic          spawn_wr, tick_done;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;
    assign stall    = o_vld && pend_vld_reg && !out_free;
    assign adv      = !stall;
    assign issue_v  = ((state_reg == ST_SCAN) || (state_reg == ST_TICK))
                      && (cnt_reg < CW'(POOL_SIZE));
    assign rd_addr  = (state_reg == ST_SCAN) ? scan_addr_reg : cnt_reg[IW-1:0];
    assign spawn_wr = (state_reg == ST_SPWR) && out_free;

    // spawn search looks at the word read in the previous cycle
    assign scan_hit   = (state_reg == ST_SCAN) && a_vld_reg
                        && (!lv_q || ($signed(life_q) <= 0));
    assign scan_miss  = (state_reg == ST_SCAN) && a_vld_reg && !scan_hit && a_last_reg;
    assign calc_start = scan_hit || scan_miss;

    // tick stage A: age the particle, apply gravity to speed y
    assign tick_a   = a_vld_reg && (state_reg == ST_TICK);
    assign alive0   = lv_q && ($signed(life_q) > 0);
    assign life_new = life_q - {16'd0, delta_reg};
    assign surv     = alive0 && ($signed(life_new) > 0);
    assign spdy_new = sat32({{3{part_q.spd_y[31]}}, part_q.spd_y} - {16'd0, gstep_reg});

    assign b_spd[0] = b_part_reg.spd_x;
    assign b_spd[1] = b_part_reg.spd_y;
    assign b_spd[2] = b_part_reg.spd_z;
    assign c_pos[0] = c_part_reg.pos_x;
    assign c_pos[1] = c_part_reg.pos_y;
    assign c_pos[2] = c_part_reg.pos_z;

    // tick stage C: move, then difference to the camera
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pos_new[k] = sat32({{3{c_pos[k][31]}}, c_pos[k]}
                               + {c_prod_reg[k][49], c_prod_reg[k][49:16]});
            diff[k]    = {pos_new[k][31], pos_new[k]} - {cam_reg[k][31], cam_reg[k]};
        end
        c_part_new       = c_part_reg;
        c_part_new.pos_x = pos_new[0];
        c_part_new.pos_y = pos_new[1];
        c_part_new.pos_z = pos_new[2];
    end

    always_comb begin
        spawn_part = '{alpha: alpha_reg, blue: blue_reg, green: green_reg, red: red_reg,
                       size: calc_size, spd_z: calc_spd_z, spd_y: calc_spd_y,
                       spd_x: calc_spd_x, pos_z: POS_Z_INIT, pos_y: 32'd0, pos_x: 32'd0};
        spawn_res  = '{last: 1'b1, empty: 1'b0, dsq: 63'd0, alpha: alpha_reg,
                       blue: blue_reg, green: green_reg, red: red_reg, size: calc_size,
                       pos_z: POS_Z_INIT, pos_y: 32'd0, pos_x: 32'd0, slot: 6'(slot_reg)};
        empty_res_w       = '0;
        empty_res_w.empty = 1'b1;
        empty_res_w.last  = 1'b1;
        b_part_in         = part_q;
        b_part_in.spd_y   = spdy_new;
        pend_last         = pend_reg;
        pend_last.last    = 1'b1;
    end

    // write ports: spawn and tick never overlap
    always_comb begin
        life_we = 1'b0;
        life_wa = a_slot_reg;
        life_wd = life_new;
        part_we = 1'b0;
        part_wa = c_slot_reg;
        part_wd = c_part_new;
        if (spawn_wr) begin
            life_we = 1'b1;
            life_wa = slot_reg;
            life_wd = LIFE_INIT;
            part_we = 1'b1;
            part_wa = slot_reg;
            part_wd = spawn_part;
        end else begin
            life_we = adv && tick_a && alive0;
            part_we = adv && c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (life_we) begin
            life_mem[life_wa] <= life_wd;
        end
        if (adv) begin
            life_q <= life_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (part_we) begin
            part_mem[part_wa] <= part_wd;
        end
        if (adv) begin
            part_q <= part_mem[rd_addr];
        end
    end

    assign tick_done = (cnt_reg == CW'(POOL_SIZE)) && !a_vld_reg && !b_vld_reg
                       && !c_vld_reg && !d_vld_reg && !dist_busy;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = s_tuser ? ST_TICK : ST_SCAN;
            ST_SCAN: if (calc_start) state_next = ST_CALC;
            ST_CALC: if (calc_done) state_next = ST_SPWR;
            ST_SPWR: if (out_free) state_next = ST_IDLE;
            ST_TICK: if (tick_done) state_next = ST_TEND;
            ST_TEND: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            lu_reg       <= '0;
            cnt_reg      <= '0;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            c_vld_reg    <= 1'b0;
            d_vld_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                cnt_reg <= '0;
            end else if (adv && issue_v) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (adv) begin
                a_vld_reg <= issue_v;
                b_vld_reg <= tick_a && surv;
                c_vld_reg <= b_vld_reg;
                d_vld_reg <= c_vld_reg;
            end
            if (spawn_wr) begin
                valid_reg[slot_reg] <= 1'b1;
                if (found_reg) begin
                    lu_reg <= slot_reg;
                end
            end
            // hold one survivor back so the final one can carry tlast
            if (adv && o_vld) begin
                pend_vld_reg <= 1'b1;
            end else if ((state_reg == ST_TEND) && out_free) begin
                pend_vld_reg <= 1'b0;
            end
            if (spawn_wr || ((state_reg == ST_TEND) && out_free)
                || (o_vld && pend_vld_reg && out_free)) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dir_x_reg     <= s_tdata[10:0];
            dir_y_reg     <= s_tdata[21:11];
            dir_z_reg     <= s_tdata[32:22];
            red_reg       <= s_tdata[40:33];
            green_reg     <= s_tdata[48:41];
            blue_reg      <= s_tdata[56:49];
            alpha_reg     <= {1'b0, s_tdata[63:57]};
            size_code_reg <= s_tdata[73:64];
            delta_reg     <= s_tdata[89:74];
            cam_reg[0]    <= s_tdata[121:90];
            cam_reg[1]    <= s_tdata[185:154];
            cam_reg[2]    <= s_tdata[153:122];
            scan_addr_reg <= lu_reg;
        end else if (adv && issue_v && (state_reg == ST_SCAN)) begin
            scan_addr_reg <= (scan_addr_reg == IW'(POOL_SIZE - 1))
                             ? '0 : scan_addr_reg + IW'(1);
        end
        gstep_reg <= 19'((37'(GRAV_K) * 37'(delta_reg) + 37'd65536) >> 17);
        if (adv) begin
            lv_q       <= valid_reg[rd_addr];
            a_slot_reg <= rd_addr;
            a_last_reg <= (cnt_reg == CW'(POOL_SIZE - 1));
            b_slot_reg <= a_slot_reg;
            b_part_reg <= b_part_in;
            c_slot_reg <= b_slot_reg;
            c_part_reg <= b_part_reg;
            for (int k = 0; k < 3; k++) begin
                c_prod_reg[k] <= $signed(b_spd[k]) * $signed({1'b0, delta_reg})
                                 + 50'sd32768;
                d_mag_reg[k]  <= diff[k][32] ? 32'(-diff[k]) : diff[k][31:0];
            end
            d_res_reg <= '{last: 1'b0, empty: 1'b0, dsq: 63'd0,
                           alpha: c_part_reg.alpha, blue: c_part_reg.blue,
                           green: c_part_reg.green, red: c_part_reg.red,
                           size: c_part_reg.size, pos_z: pos_new[2], pos_y: pos_new[1],
                           pos_x: pos_new[0], slot: 6'(c_slot_reg)};
        end
        if (scan_hit) begin
            found_reg <= 1'b1;
            slot_reg  <= a_slot_reg;
        end else if (scan_miss) begin
            found_reg <= 1'b0;
            slot_reg  <= '0;
        end
        if (adv && o_vld) begin
            pend_reg <= o_res;
        end
        if (spawn_wr) begin
            out_reg <= spawn_res;
        end else if ((state_reg == ST_TEND) && out_free) begin
            if (pend_vld_reg) begin
                out_reg <= pend_last;
            end else begin
                out_reg <= empty_res_w;
            end
        end else if (o_vld && pend_vld_reg && out_free) begin
            out_reg <= pend_reg;
        end
    end

    ppsim_spawn_calc u_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (calc_start),
        .dir_x     (dir_x_reg),
        .dir_y     (dir_y_reg),
        .dir_z     (dir_z_reg),
        .size_code (size_code_reg),
        .done      (calc_done),
        .spd_x     (calc_spd_x),
        .spd_y     (calc_spd_y),
        .spd_z     (calc_spd_z),
        .size      (calc_size)
    );

    ppsim_dist_sq u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_vld  (d_vld_reg),
        .in_res  (d_res_reg),
        .in_mag  (d_mag_reg),
        .out_vld (o_vld),
        .out_res (o_res),
        .busy    (dist_busy)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_reg.dsq, out_reg.alpha, out_reg.blue, out_reg.green,
                       out_reg.red, out_reg.size, out_reg.pos_z, out_reg.pos_y,
                       out_reg.pos_x, out_reg.slot};
    assign m_tuser  = out_reg.empty;
    assign m_tlast  = out_reg.last;

    `PPSIM_IMPLY(a_idle_drained, state_reg == ST_IDLE,
                 !b_vld_reg && !c_vld_reg && !d_vld_reg && !dist_busy && !pend_vld_reg,
                 "pipeline or pending word left over in idle")
    `PPSIM_NEVER(a_stall_only_tick, stall && (state_reg != ST_TICK),
                 "pipeline stall outside a tick")
    `PPSIM_NEXT(a_spawn_marks_valid, spawn_wr, valid_reg[slot_reg] && m_tvalid && m_tlast,
                "spawn did not mark its slot or present its word")
    `PPSIM_IMPLY(a_end_after_drain, state_reg == ST_TEND,
                 !a_vld_reg && !b_vld_reg && !c_vld_reg && !o_vld,
                 "tick closed before its pipeline drained")

endmodule

// ===== test/particle_pool_simulator_tb.sv =====
// Testbench for particle_pool_simulator: directed table, then random spawn and tick words,
// with each result compared against a local particle pool predictor.
// Depends only on the RTL of the block.
module particle_pool_simulator_tb;

    localparam int          POOL       = 64;
    localparam bit          OP_SPAWN   = 1'b0;
    localparam bit          OP_TICK    = 1'b1;
    localparam int          WATCH_MAX  = 5000;
    localparam logic [62:0] DIST_SAT   = {63{1'b1}};
    localparam int          N_RANDOM   = 500;
    localparam int          N_QUIET    = 80;

    typedef struct {
        bit        op;
        int        dx, dy, dz;
        bit [7:0]  r, g, b;
        bit [6:0]  a;
        bit [9:0]  sz;
        bit [15:0] dt;
        bit [31:0] cx;
        bit [63:0] cyz;
    } cmd_t;

    typedef struct {
        bit [5:0]  slot;
        bit [31:0] x, y, z;
        bit [15:0] size;
        bit [7:0]  r, g, b, a;
        bit [62:0] dsq;
        bit        empty, last;
    } rpt_t;

    typedef struct {
        cmd_t c;
        bit   typed;
        rpt_t e;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [215:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    particle_pool_simulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // pool image kept by the predictor
    int        life[POOL];
    int        px[POOL], py[POOL], pz[POOL];
    int        vx[POOL], vy[POOL], vz[POOL];
    bit [15:0] psize[POOL];
    bit [7:0]  pr[POOL], pg[POOL], pb[POOL], pa[POOL];
    int        last_slot;

    rpt_t      pending[$];
    rpt_t      fresh[$];
    int        errors = 0;
    int        n_words = 0;
    int        n_reports = 0;
    int        n_spawns = 0;
    int        n_ticks = 0;
    int        n_full = 0;
    bit        quiet = 1'b0;
    int        idle_cnt = 0;
    int        stall_cnt = 0;

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic int dir_to_speed(int d);
        longint p;
        p = longint'(d) * 98304;
        if (p >= 0) return int'((p + 500) / 1000);
        return -int'((-p + 500) / 1000);
    endfunction

    function automatic rpt_t report_of(int s, bit [62:0] dsq);
        rpt_t e;
        e = '{default: '0};
        e.slot = s[5:0];
        e.x = px[s]; e.y = py[s]; e.z = pz[s];
        e.size = psize[s];
        e.r = pr[s]; e.g = pg[s]; e.b = pb[s]; e.a = pa[s];
        e.dsq = dsq;
        return e;
    endfunction

    // advance the pool image by one command, leaving its reports in fresh
    task automatic advance_pool(cmd_t c);
        int        s, i, k;
        bit        found;
        longint    gstep, st, cam[3];
        logic [127:0] acc, m;
        longint    d;
        int        p3[3];
        int        v3[3];
        rpt_t      e;
        fresh.delete();
        if (c.op == OP_SPAWN) begin
            n_spawns++;
            found = 1'b0;
            s = 0;
            for (i = 0; i < POOL && !found; i++) begin
                k = (last_slot + i) % POOL;
                if (life[k] <= 0) begin
                    s = k;
                    found = 1'b1;
                end
            end
            if (found) last_slot = s;
            else n_full++;
            life[s] = 5 * 65536;
            px[s] = 0; py[s] = 0; pz[s] = -20 * 65536;
            vx[s] = dir_to_speed(c.dx);
            vy[s] = 10 * 65536 + dir_to_speed(c.dy);
            vz[s] = dir_to_speed(c.dz);
            pr[s] = c.r; pg[s] = c.g; pb[s] = c.b; pa[s] = {1'b0, c.a};
            psize[s] = 16'(((int'(c.sz) + 200) * 4096 + 62) / 125);
            e = report_of(s, '0);
            e.last = 1'b1;
            fresh.push_back(e);
        end else begin
            n_ticks++;
            gstep = (longint'(642908) * longint'(c.dt) + 65536) >>> 17;
            cam[0] = longint'($signed(c.cx));
            cam[1] = longint'($signed(c.cyz[63:32]));
            cam[2] = longint'($signed(c.cyz[31:0]));
            for (s = 0; s < POOL; s++) begin
                if (life[s] <= 0) continue;
                life[s] = clamp32(longint'(life[s]) - longint'(c.dt));
                if (life[s] <= 0) continue;
                vy[s] = clamp32(longint'(vy[s]) - gstep);
                p3 = '{px[s], py[s], pz[s]};
                v3 = '{vx[s], vy[s], vz[s]};
                acc = '0;
                for (k = 0; k < 3; k++) begin
                    st = (longint'(v3[k]) * longint'(c.dt) + 32768) >>> 16;
                    p3[k] = clamp32(longint'(p3[k]) + st);
                    d = longint'(p3[k]) - cam[k];
                    m = (d < 0) ? 128'(-d) : 128'(d);
                    acc = acc + m * m;
                end
                px[s] = p3[0]; py[s] = p3[1]; pz[s] = p3[2];
                fresh.push_back(report_of(s, (acc > 128'(DIST_SAT)) ? DIST_SAT : acc[62:0]));
            end
            if (fresh.size() == 0) begin
                e = '{default: '0};
                e.empty = 1'b1;
                fresh.push_back(e);
            end
            fresh[fresh.size() - 1].last = 1'b1;
        end
    endtask

    // drive one word and hold it until accepted
    task automatic send_word(cmd_t c, bit typed, rpt_t e);
        int gap;
        advance_pool(c);
        if (typed) pending.push_back(e);
        else foreach (fresh[i]) pending.push_back(fresh[i]);
        s_tuser <= c.op;
        s_tdata <= {6'b0, c.cyz, c.cx, c.dt, c.sz, c.a, c.b, c.g, c.r,
                    c.dz[10:0], c.dy[10:0], c.dx[10:0]};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        n_words++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: mismatch %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // result side: compare accepted words, then decide the next ready
    always @(posedge aclk) begin
        rpt_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_reports++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                e = pending.pop_front();
                check_field("slot", 64'(e.slot), 64'(m_tdata[5:0]));
                check_field("pos_x", 64'(e.x), 64'(m_tdata[37:6]));
                check_field("pos_y", 64'(e.y), 64'(m_tdata[69:38]));
                check_field("pos_z", 64'(e.z), 64'(m_tdata[101:70]));
                check_field("size_out", 64'(e.size), 64'(m_tdata[117:102]));
                check_field("red_out", 64'(e.r), 64'(m_tdata[125:118]));
                check_field("green_out", 64'(e.g), 64'(m_tdata[133:126]));
                check_field("blue_out", 64'(e.b), 64'(m_tdata[141:134]));
                check_field("alpha_out", 64'(e.a), 64'(m_tdata[149:142]));
                check_field("distance_sq", 64'(e.dsq), 64'(m_tdata[212:150]));
                check_field("empty_res", 64'(e.empty), 64'(m_tuser));
                check_field("last", 64'(e.last), 64'(m_tlast));
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_cnt <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else if (aresetn) begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WATCH_MAX) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCH_MAX);
                $display("particle_pool_simulator_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic cmd_t mk(bit op, int dx, int dy, int dz, int r, int g, int b, int a,
                                int sz, int dt, bit [31:0] cx, bit [63:0] cyz);
        cmd_t c;
        c.op = op; c.dx = dx; c.dy = dy; c.dz = dz;
        c.r = 8'(r); c.g = 8'(g); c.b = 8'(b); c.a = 7'(a); c.sz = 10'(sz);
        c.dt = 16'(dt);
        c.cx = cx; c.cyz = cyz;
        return c;
    endfunction

    function automatic cmd_t rand_cmd(bit fill);
        cmd_t c;
        int   pick;
        c.op = fill ? OP_SPAWN : ($urandom_range(0, 99) < 55 ? OP_SPAWN : OP_TICK);
        c.dx = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 999 : -1000)
                                         : $urandom_range(0, 1999) - 1000;
        c.dy = $urandom_range(0, 1999) - 1000;
        c.dz = $urandom_range(0, 1999) - 1000;
        c.r = 8'($urandom); c.g = 8'($urandom); c.b = 8'($urandom);
        c.a = 7'($urandom_range(0, 85));
        c.sz = 10'($urandom_range(0, 999));
        pick = $urandom_range(0, 9);
        if (pick < 7) c.dt = 16'($urandom_range(0, 4000));
        else if (pick < 9) c.dt = 16'($urandom);
        else c.dt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 4) == 0) begin
            c.cx = $urandom;
            c.cyz = {$urandom, $urandom};
        end else begin
            c.cx = 32'($signed($urandom_range(0, 200 * 65536)) - 100 * 65536);
            c.cyz = {32'($signed($urandom_range(0, 200 * 65536)) - 100 * 65536),
                     32'($signed($urandom_range(0, 200 * 65536)) - 100 * 65536)};
        end
        return c;
    endfunction

    initial begin
        row_t   rows[$];
        row_t   rw;
        rpt_t   none;
        int     i;
        none = '{default: '0};
        for (i = 0; i < POOL; i++) begin
            life[i] = -65536;
            px[i] = 0; py[i] = 0; pz[i] = 0; vx[i] = 0; vy[i] = 0; vz[i] = 0;
            psize[i] = 0; pr[i] = 0; pg[i] = 0; pb[i] = 0; pa[i] = 0;
        end
        last_slot = 0;

        // tick on an empty pool right after reset
        rw.c = mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1000, 0, 0);
        rw.typed = 1'b1; rw.e = none; rw.e.empty = 1'b1; rw.e.last = 1'b1;
        rows.push_back(rw);
        // first spawn lands in slot 0 at the start position
        rw.c = mk(OP_SPAWN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        rw.e = none; rw.e.z = 32'hFFEC_0000; rw.e.size = 16'd6554; rw.e.last = 1'b1;
        rows.push_back(rw);
        rw.c = mk(OP_SPAWN, 999, 999, 999, 255, 255, 255, 85, 999, 65535, '1, '1);
        rw.e = none; rw.e.slot = 6'd1; rw.e.z = 32'hFFEC_0000; rw.e.size = 16'd39289;
        rw.e.r = 8'hFF; rw.e.g = 8'hFF; rw.e.b = 8'hFF; rw.e.a = 8'd85; rw.e.last = 1'b1;
        rows.push_back(rw);
        rw.typed = 1'b0;
        rw.c = mk(OP_SPAWN, -1000, -1000, -1000, 1, 2, 4, 64, 512, 0, 0, 0);
        rows.push_back(rw);
        rw.c = mk(OP_SPAWN, 500, -1, 1, 128, 64, 32, 42, 1, 0, 0, 0);
        rows.push_back(rw);
        rw.c = mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(rw);
        rw.c = mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 3277, 32'h0001_0000, 64'h0002_0000_FFEC_0000);
        rows.push_back(rw);
        // far camera corners drive the distance into saturation
        rw.c = mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'h8000_0000, 64'h8000_0000_8000_0000);
        rows.push_back(rw);
        rw.c = mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF);
        rows.push_back(rw);
        // long ticks until every particle has died
        for (i = 0; i < 6; i++) begin
            rw.c = mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 65535, 0, 0);
            rows.push_back(rw);
        end
        rw.c = mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 65535, 0, 0);
        rw.typed = 1'b1; rw.e = none; rw.e.empty = 1'b1; rw.e.last = 1'b1;
        rows.push_back(rw);
        rw.typed = 1'b0;
        rw.c = mk(OP_SPAWN, 3, -7, 11, 9, 8, 7, 6, 5, 0, 0, 0);
        rows.push_back(rw);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[j]) send_word(rows[j].c, rows[j].typed, rows[j].e);

        // fill the pool past capacity early on, then mixed traffic
        for (i = 0; i < N_RANDOM; i++) begin
            quiet = (i >= N_RANDOM - N_QUIET);
            send_word(rand_cmd(i >= 40 && i < 110), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("covered %0d words (%0d spawns, %0d ticks, %0d on a full pool), %0d results",
                 n_words, n_spawns, n_ticks, n_full, n_reports);
        if (errors == 0 && pending.size() == 0) begin
            $display("particle_pool_simulator_tb OK");
        end else begin
            $display("%0d mismatches, %0d results still expected", errors, pending.size());
            $display("particle_pool_simulator_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ppsim_pkg.sv
rtl/ppsim_spawn_calc.sv
rtl/ppsim_dist_sq.sv
rtl/particle_pool_simulator.sv
test/particle_pool_simulator_tb.sv
